>>> sv/sdn_pkg.sv
`timescale 1ns / 1ps
// sdn_pkg: shared types and constants for the sample depth normalizer
// used by sdn_prep, sdn_cell and sample_depth_normalizer_top

package sdn_pkg;

  // word and register widths
  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_CELLS = SAMPLE_W;

  // register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_IS_ZERO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LITTLE_ENDIAN  = 2'd2;

  // depth register reset value, depth bounds and the byte and word depths
  localparam logic [CFG_W-1:0] DEPTH_RESET = 5'd8;
  localparam logic [CFG_W-1:0] DEPTH_MIN   = 5'd1;
  localparam logic [CFG_W-1:0] DEPTH_BYTE  = 5'd8;
  localparam logic [CFG_W-1:0] DEPTH_WORD  = 5'd16;

  // payload handed from cell to cell along the divider row
  typedef struct packed {
    logic [SAMPLE_W-1:0] rem;      // partial remainder, always below divisor
    logic [SAMPLE_W-1:0] work;     // dividend bits out on top, quotient bits in below
    logic [SAMPLE_W-1:0] divisor;  // depth maximum, or one for pass-through
    logic                invert;   // white-is-zero inversion at the end
    logic                clamped;  // sample was above the depth maximum
  } sdn_word_t;

endpackage

>>> sv/sdn_prep.sv
`timescale 1ns / 1ps
// sdn_prep: configuration registers and front stage (clamp, byte swap, dividend)
// depends on sdn_pkg

module sdn_prep
  import sdn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  input  logic                 in_valid,
  input  logic [SAMPLE_W-1:0]  raw_sample,
  output logic                 out_valid,
  output sdn_word_t            out_word
);

  logic [CFG_W-1:0]      depth_setting;
  logic                  white_is_zero;
  logic                  little_endian_words;

  logic [CFG_W-1:0]      depth_eff;
  logic                  shallow;
  logic                  pass_thru;
  logic [SAMPLE_W:0]     max_wide;
  logic [SAMPLE_W-1:0]   max_val;
  logic [SAMPLE_W-1:0]   sample_sel;
  logic                  over;
  logic [SAMPLE_W-1:0]   sample_clip;
  logic [2*SAMPLE_W-1:0] scaled_num;
  logic [2*SAMPLE_W-1:0] dividend;
  logic [SAMPLE_W-1:0]   divisor;
  sdn_word_t             word_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_setting       <= DEPTH_RESET;
      white_is_zero       <= 1'b0;
      little_endian_words <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEPTH:         depth_setting       <= wr_data;
        REG_WHITE_IS_ZERO: white_is_zero       <= wr_data[0];
        REG_LITTLE_ENDIAN: little_endian_words <= wr_data[0];
        default: ;
      endcase
    end
  end

  // effective depth and its maximum value
  always_comb begin
    if (depth_setting == '0) begin
      depth_eff = DEPTH_MIN;
    end else if (depth_setting > DEPTH_WORD) begin
      depth_eff = DEPTH_WORD;
    end else begin
      depth_eff = depth_setting;
    end
    shallow   = (depth_eff <= DEPTH_BYTE);
    pass_thru = (depth_eff == DEPTH_BYTE) || (depth_eff == DEPTH_WORD);
    max_wide  = ((SAMPLE_W+1)'(1) << depth_eff) - (SAMPLE_W+1)'(1);
    max_val   = max_wide[SAMPLE_W-1:0];
  end

  // byte select or swap, then clamp
  always_comb begin
    if (shallow) begin
      sample_sel = {8'd0, raw_sample[7:0]};
    end else if (little_endian_words) begin
      sample_sel = {raw_sample[7:0], raw_sample[15:8]};
    end else begin
      sample_sel = raw_sample;
    end
    over        = !pass_thru && (sample_sel > max_val);
    sample_clip = over ? max_val : sample_sel;
  end

  // dividend s*(2^w - 1) + m/2 by shift and subtract; divide by one to pass through
  always_comb begin
    if (shallow) begin
      scaled_num = ((2*SAMPLE_W)'(sample_clip) << 8) - (2*SAMPLE_W)'(sample_clip);
    end else begin
      scaled_num = ((2*SAMPLE_W)'(sample_clip) << SAMPLE_W) - (2*SAMPLE_W)'(sample_clip);
    end
    if (pass_thru) begin
      dividend = (2*SAMPLE_W)'(sample_clip);
      divisor  = SAMPLE_W'(1);
    end else begin
      dividend = scaled_num + (2*SAMPLE_W)'(max_val >> 1);
      divisor  = max_val;
    end
    word_next.rem     = dividend[2*SAMPLE_W-1:SAMPLE_W];
    word_next.work    = dividend[SAMPLE_W-1:0];
    word_next.divisor = divisor;
    word_next.invert  = shallow && white_is_zero;
    word_next.clamped = over;
  end

  // front stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

>>> sv/sdn_cell.sv
`timescale 1ns / 1ps
// sdn_cell: one restoring-division step, yields one quotient bit per word
// depends on sdn_pkg

module sdn_cell
  import sdn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  sdn_word_t in_word,
  output logic      out_valid,
  output sdn_word_t out_word
);

  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W+1:0] diff;
  logic                fits;
  sdn_word_t           word_next;

  // shift in the next dividend bit, subtract when the divisor fits
  always_comb begin
    trial     = {in_word.rem, in_word.work[SAMPLE_W-1]};
    diff      = {1'b0, trial} - {2'b00, in_word.divisor};
    fits      = !diff[SAMPLE_W+1];
    word_next = in_word;
    word_next.rem  = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
    word_next.work = {in_word.work[SAMPLE_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

>>> sv/sample_depth_normalizer_top.sv
`timescale 1ns / 1ps
// sample_depth_normalizer_top: front stage followed by a row of division cells
// depends on sdn_pkg, sdn_prep, sdn_cell
//
// Usage:
//   A raw sample is taken on raw_sample at each rising edge with start high
//   and busy low. busy is always low, so one sample may enter every cycle.
//   Each sample gives one word on scaled_sample and clamped, marked by done
//   for one cycle. The front stage (depth decode, byte swap, clamp,
//   dividend) loads on the taking edge, then each cell of a row of 16
//   division cells registers one quotient bit in turn; done rises as the
//   word leaves the last cell.
//   Words leave in the order samples came.
//   Throughput is one sample per cycle; the cells each hold one word in
//   flight and hand it to the next cell every cycle.
//   The receiver cannot stall: done words must be taken when shown.
//   Registers are written over wr_en, wr_index and wr_data. The user must
//   write them only while no sample is in flight; the block does not check.
//   Reset sets depth 8, no inversion, big-endian words, drops any word in flight.

module sample_depth_normalizer_top
  import sdn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [SAMPLE_W-1:0]  raw_sample,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output logic                 done,
  output logic [SAMPLE_W-1:0]  scaled_sample,
  output logic                 clamped
);

  logic      link_valid [0:NUM_CELLS];
  sdn_word_t link_word  [0:NUM_CELLS];

  // always ready for a new sample
  assign busy = 1'b0;

  // front stage
  sdn_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (start && !busy),
    .raw_sample (raw_sample),
    .out_valid  (link_valid[0]),
    .out_word   (link_word[0])
  );

  // row of division cells, one quotient bit each
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    sdn_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[i]),
      .in_word   (link_word[i]),
      .out_valid (link_valid[i+1]),
      .out_word  (link_word[i+1])
    );
  end

  // quotient out, inverted for white-is-zero at shallow depth
  assign done          = link_valid[NUM_CELLS];
  assign scaled_sample = link_word[NUM_CELLS].invert
                         ? {8'd0, ~link_word[NUM_CELLS].work[7:0]}
                         : link_word[NUM_CELLS].work;
  assign clamped       = link_word[NUM_CELLS].clamped;

endmodule

>>> tb/sv/sample_depth_normalizer_top_tb.sv
`timescale 1ns / 1ps
// sample_depth_normalizer_top_tb: self-checking bench for the depth normalizer,
// with directed corner samples and then random samples over many register settings
// depends on sdn_pkg and sample_depth_normalizer_top

module sample_depth_normalizer_top_tb;
  import sdn_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS = 1100;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // one expected output word
  typedef struct {
    logic [SAMPLE_W-1:0] scaled;
    logic                clip;
  } scaled_word_t;

  // scoreboard: private copy of the registers plus the queue of pending words
  class depth_scoreboard;
    logic [CFG_W-1:0] depth_reg;
    logic             invert_reg;
    logic             swap_reg;
    scaled_word_t     pending_q[$];
    int               errors;
    int               words_seen;

    function new();
      depth_reg  = DEPTH_RESET;
      invert_reg = 1'b0;
      swap_reg   = 1'b0;
      errors     = 0;
      words_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_DEPTH:         depth_reg  = data;
        REG_WHITE_IS_ZERO: invert_reg = data[0];
        REG_LITTLE_ENDIAN: swap_reg   = data[0];
        default: ;
      endcase
    endfunction

    // rescale one raw sample under the current registers
    function void note_sample(logic [SAMPLE_W-1:0] raw);
      logic [4:0]   d;
      logic [63:0]  top;
      logic [63:0]  s;
      scaled_word_t w;
      d = depth_reg;
      if (d == 5'd0) d = DEPTH_MIN;
      if (d > DEPTH_WORD) d = DEPTH_WORD;
      top = (64'd1 << d) - 64'd1;
      s = {48'd0, raw};
      w.clip = 1'b0;
      if (d <= DEPTH_BYTE) begin
        s = s & 64'hFF;
        if (d < DEPTH_BYTE) begin
          if (s > top) begin
            s = top;
            w.clip = 1'b1;
          end
          s = (s * 64'd255 + top / 64'd2) / top;
        end
        if (invert_reg) s = 64'd255 - s;
        w.scaled = {8'd0, s[7:0]};
      end else begin
        if (swap_reg) s = {48'd0, s[7:0], s[15:8]};
        if (d < DEPTH_WORD) begin
          if (s > top) begin
            s = top;
            w.clip = 1'b1;
          end
          s = (s * 64'd65535 + top / 64'd2) / top;
        end
        w.scaled = s[15:0];
      end
      pending_q.push_back(w);
    endfunction

    function void check_word(logic [SAMPLE_W-1:0] scaled, logic clip);
      scaled_word_t w;
      words_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected word: scaled_sample %0d clamped %0d", scaled, clip);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (scaled !== w.scaled) begin
        $error("scaled_sample: expected %0d actual %0d", w.scaled, scaled);
        errors++;
      end
      if (clip !== w.clip) begin
        $error("clamped: expected %0d actual %0d", w.clip, clip);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [SAMPLE_W-1:0]  raw_sample;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;
  logic                 done;
  logic [SAMPLE_W-1:0]  scaled_sample;
  logic                 clamped;

  depth_scoreboard sb = new();
  int cycles = 0;
  int items_sent = 0;
  int settings_run = 0;

  // settings as last written, used to shape the random samples
  logic [CFG_W-1:0] cur_depth = DEPTH_RESET;
  logic             cur_swap = 1'b0;

  sample_depth_normalizer_top uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .raw_sample   (raw_sample),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .done         (done),
    .scaled_sample(scaled_sample),
    .clamped      (clamped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watch the ports at each rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) sb.write_reg(wr_index, wr_data);
      if (start && !busy) sb.note_sample(raw_sample);
      if (done) sb.check_word(scaled_sample, clamped);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // present one sample, with random idle cycles ahead of it
  task automatic send_sample(logic [SAMPLE_W-1:0] val, int idle_pct);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start      <= 1'b0;
      raw_sample <= SAMPLE_W'($urandom);
      @(negedge clk);
    end
    start      <= 1'b1;
    raw_sample <= val;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // stop sending and wait until every word has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all registers while nothing is in flight
  task automatic set_regs(logic [CFG_W-1:0] depth, logic inv, logic swp, logic junk);
    drain();
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_DEPTH;
    wr_data  <= depth;
    @(negedge clk);
    wr_index <= REG_WHITE_IS_ZERO;
    wr_data  <= junk ? {4'($urandom), inv} : {4'd0, inv};
    @(negedge clk);
    wr_index <= REG_LITTLE_ENDIAN;
    wr_data  <= junk ? {4'($urandom), swp} : {4'd0, swp};
    @(negedge clk);
    // the spare index must change nothing
    wr_index <= REG_UNUSED;
    wr_data  <= CFG_W'($urandom);
    @(negedge clk);
    wr_en    <= 1'b0;
    wr_index <= CFG_IDX_W'($urandom);
    wr_data  <= CFG_W'($urandom);
    cur_depth = depth;
    cur_swap  = swp;
    settings_run++;
  endtask

  // random sample aimed at the current depth: in range, at the maximum, just over it, or anything
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int          d;
    int unsigned top;
    int unsigned v;
    d = int'(cur_depth);
    if (d == 0) d = 1;
    if (d > 16) d = 16;
    top = (1 << d) - 1;
    case ($urandom_range(0, 5))
      0:       v = top;
      1:       v = top + 1;
      2:       v = 0;
      3:       v = $urandom_range(0, 65535);
      default: v = $urandom_range(0, top);
    endcase
    if (d <= 8) return {8'($urandom), 8'(v)};
    if (v > 65535) v = $urandom_range(0, 65535);
    if (cur_swap) return {v[7:0], v[15:8]};
    return 16'(v);
  endfunction

  initial begin
    int idle_pct;
    int phase_len;
    int n;
    rst        = 1'b1;
    start      = 1'b0;
    raw_sample = '0;
    wr_en      = 1'b0;
    wr_index   = '0;
    wr_data    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, byte depth passes through, upper byte ignored
    send_sample(16'h0000, 0);
    send_sample(16'h00FF, 0);
    send_sample(16'hFF80, 0);
    // depth one with inversion, clamp above one
    set_regs(5'd1, 1'b1, 1'b0, 1'b0);
    send_sample(16'h0000, 0);
    send_sample(16'h0001, 0);
    send_sample(16'h0002, 0);
    send_sample(16'hFFFF, 0);
    // depth seven, swap has no effect at shallow depth
    set_regs(5'd7, 1'b0, 1'b1, 1'b0);
    send_sample(16'h007F, 0);
    send_sample(16'h0080, 0);
    // depth nine, swapped bytes, inversion ignored
    set_regs(5'd9, 1'b1, 1'b1, 1'b0);
    send_sample(16'h0100, 0);
    send_sample(16'hFF01, 0);
    send_sample(16'h0002, 0);
    // full word depth passes through
    set_regs(DEPTH_WORD, 1'b0, 1'b1, 1'b0);
    send_sample(16'h1234, 0);
    send_sample(16'hFFFF, 0);
    set_regs(5'd15, 1'b0, 1'b0, 1'b0);
    send_sample(16'h8000, 0);
    send_sample(16'h7FFF, 0);
    // depth zero acts as one, depths above sixteen act as sixteen
    set_regs(5'd0, 1'b0, 1'b0, 1'b0);
    send_sample(16'h0001, 0);
    send_sample(16'h0003, 0);
    set_regs(5'd31, 1'b1, 1'b0, 1'b0);
    send_sample(16'hABCD, 0);
    send_sample(16'h0000, 0);
    set_regs(DEPTH_BYTE, 1'b1, 1'b1, 1'b0);
    send_sample(16'h00AB, 0);

    // random phases, each under a fresh setting
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0)
        set_regs(5'($urandom_range(0, 31)), 1'($urandom), 1'($urandom), 1'b1);
      else
        set_regs(5'($urandom_range(1, 16)), 1'($urandom), 1'($urandom), 1'b1);
      phase_len = $urandom_range(20, 80);
      for (int i = 0; i < phase_len && n < RANDOM_ITEMS; i++) begin
        if (n < RANDOM_ITEMS / 3) idle_pct = 27;
        else if (n < 2 * RANDOM_ITEMS / 3) idle_pct = 56;
        else idle_pct = 0;
        send_sample(pick_sample(), idle_pct);
        n++;
      end
    end

    drain();
    $display("sent %0d samples under %0d register settings, %0d words checked",
             items_sent, settings_run, sb.words_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
